@@ hdl/uart_receive_ring_with_error_capture_unit_macros.svh @@
// Assertion helpers for the receive ring
`ifndef UART_RECEIVE_RING_WITH_ERROR_CAPTURE_UNIT_MACROS_SVH
`define UART_RECEIVE_RING_WITH_ERROR_CAPTURE_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define URREC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, also during reset
`define URREC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/urrec_pkg.sv @@
package urrec_pkg;

  localparam int RING_DEPTH_DEF = 2048;

  localparam int DATA_W     = 8;
  localparam int LINE_ERR_W = 4;
  localparam int FLAG_W     = 5;
  localparam int FLAG_OVF   = 4;
  localparam int COUNT_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_RECEIVE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_DIAG    = 2'd2
  } cmd_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } ring_ctl_t;

endpackage

@@ hdl/urrec_ram.sv @@
module urrec_ram #(
  parameter int DEPTH  = urrec_pkg::RING_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  urrec_pkg::ring_ctl_t          ctl,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [urrec_pkg::DATA_W-1:0]  wdata,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [urrec_pkg::DATA_W-1:0]  rdata
);

  logic [urrec_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/uart_receive_ring_with_error_capture_unit.sv @@
// Channel  Dir  Signals                    Contents
// -------  ---  -------------------------  ------------------------------------------
// s        in   s_tvalid s_tready s_tdata  tdata: rx_data, line_errors
//                              s_tuser     tuser: command, byte_received
// m        out  m_tvalid m_tready m_tdata  tdata: read_valid, read_data, push_accepted,
//                                                 notify, error_flags, dropped_count
// cfg      in   receiver_enable_we/_wdata  receiver_enable
//
// One transfer per cycle while m_tready is high; input register, then result register.
// The state update and the ring port access happen as an item leaves the input
// register; the ring's registered read port supplies read_data with the result.
// Synchronous reset clears pointers, flags, counter and enable; ring contents are
// left undefined and need no clearing pass.
// With m_tready low the result holds and one further item waits in the input register.
`include "uart_receive_ring_with_error_capture_unit_macros.svh"

module uart_receive_ring_with_error_capture_unit #(
  parameter int RING_DEPTH = urrec_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        receiver_enable_we,
  input  logic        receiver_enable_wdata,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_data, [11:8] line_errors, [15:12] zero
  input  logic [2:0]  s_tuser,   // [1:0] command, [2] byte_received

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [0] read_valid, [8:1] read_data, [9] push_accepted,
                                 // [10] notify, [15:11] error_flags, [47:16] dropped_count
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  localparam int DW = urrec_pkg::DATA_W;
  localparam int EW = urrec_pkg::LINE_ERR_W;
  localparam int FW = urrec_pkg::FLAG_W;
  localparam int CW = urrec_pkg::COUNT_W;

  logic receiver_enable;

  // input register
  logic               s1_valid;
  urrec_pkg::cmd_t    s1_cmd;
  logic               s1_has_byte;
  logic [DW-1:0]      s1_data;
  logic [EW-1:0]      s1_errs;

  // block state
  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  logic [FW-1:0]      sticky_errors, sticky_errors_next;
  logic [CW-1:0]      drop_counter, drop_counter_next;

  // result register
  logic               out_valid;
  logic               out_read_valid, out_read_valid_next;
  logic               out_push, out_push_next;
  logic [FW-1:0]      out_flags, out_flags_next;
  logic [CW-1:0]      out_count, out_count_next;

  urrec_pkg::ring_ctl_t ring_ctl;
  logic [DW-1:0]        ring_q;
  logic [PTR_W-1:0]     wp_adv, rp_adv;
  logic                 adv, move;

  assign adv      = !out_valid || m_tready;
  assign move     = s1_valid && adv;
  assign s_tready = !s1_valid || adv;

  assign wp_adv = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
  assign rp_adv = (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_enable <= 1'b0;
    end else if (receiver_enable_we) begin
      receiver_enable <= receiver_enable_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd      <= urrec_pkg::cmd_t'(s_tuser[1:0]);
      s1_has_byte <= s_tuser[2];
      s1_data     <= s_tdata[7:0];
      s1_errs     <= s_tdata[11:8];
    end
  end

  always_comb begin
    write_pointer_next  = write_pointer;
    read_pointer_next   = read_pointer;
    sticky_errors_next  = sticky_errors;
    drop_counter_next   = drop_counter;
    out_read_valid_next = 1'b0;
    out_push_next       = 1'b0;
    out_flags_next      = '0;
    out_count_next      = '0;
    ring_ctl            = '0;
    case (s1_cmd)
      urrec_pkg::CMD_RECEIVE: begin
        if (receiver_enable) begin
          sticky_errors_next = sticky_errors | {1'b0, s1_errs};
          if (s1_has_byte) begin
            if (wp_adv == read_pointer) begin
              sticky_errors_next[urrec_pkg::FLAG_OVF] = 1'b1;
              if (drop_counter != urrec_pkg::COUNT_MAX) begin
                drop_counter_next = drop_counter + 1'b1;
              end
            end else begin
              ring_ctl.wr        = 1'b1;
              write_pointer_next = wp_adv;
              out_push_next      = 1'b1;
            end
          end
        end
      end
      urrec_pkg::CMD_READ: begin
        if (receiver_enable && (read_pointer != write_pointer)) begin
          ring_ctl.rd         = 1'b1;
          read_pointer_next   = rp_adv;
          out_read_valid_next = 1'b1;
        end
      end
      urrec_pkg::CMD_DIAG: begin
        out_flags_next     = sticky_errors;
        out_count_next     = drop_counter;
        sticky_errors_next = '0;
        drop_counter_next  = '0;
      end
      default: begin
      end
    endcase
    if (!move) begin
      ring_ctl = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      sticky_errors <= '0;
      drop_counter  <= '0;
    end else if (move) begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      sticky_errors <= sticky_errors_next;
      drop_counter  <= drop_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_read_valid <= out_read_valid_next;
      out_push       <= out_push_next;
      out_flags      <= out_flags_next;
      out_count      <= out_count_next;
    end
  end

  urrec_ram #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .ctl   (ring_ctl),
    .waddr (write_pointer),
    .wdata (s1_data),
    .raddr (read_pointer),
    .rdata (ring_q)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_count, out_flags, out_push, out_push,
                     (out_read_valid ? ring_q : {DW{1'b0}}), out_read_valid};

  `URREC_ASSERT(a_push_xor_read, out_valid |-> !(out_push && out_read_valid),
                "result shows both a push and a read")
  `URREC_ASSERT(a_diag_alone, (out_valid && (out_flags != '0)) |-> (!out_push && !out_read_valid),
                "diagnostic result mixed with ring activity")
  `URREC_ASSERT(a_empty_read, (move && (s1_cmd == urrec_pkg::CMD_READ) &&
                (read_pointer == write_pointer)) |=> !out_read_valid,
                "read from empty ring returned a byte")
  `URREC_ASSERT_ALWAYS(a_ptr_range,
                       rst || ((write_pointer <= PTR_LAST) && (read_pointer <= PTR_LAST)),
                       "ring pointer out of range")

endmodule

@@ test/uart_receive_ring_with_error_capture_unit_test.sv @@
`timescale 1ns / 100ps

module uart_receive_ring_with_error_capture_unit_test;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [3:0] errs;
    logic [7:0] data;
    logic       has_byte;
    logic [1:0] cmd;
  } rx_item_t;

  // same layout as m_tdata, lowest field last
  typedef struct packed {
    logic [urrec_pkg::COUNT_W-1:0] dropped;
    logic [urrec_pkg::FLAG_W-1:0]  flags;
    logic                          notify;
    logic                          push;
    logic [urrec_pkg::DATA_W-1:0]  rdata;
    logic                          rvalid;
  } ring_result_t;

  typedef struct {
    int           cfg;
    rx_item_t     item;
    bit           typed;
    ring_result_t res;
  } dir_row_t;

  typedef enum {MIX_GENERAL, MIX_FILL, MIX_DRAIN} mix_t;

  logic        clk;
  logic        rst;
  logic        receiver_enable_we;
  logic        receiver_enable_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  // model state
  logic [urrec_pkg::DATA_W-1:0]  ring_mem [urrec_pkg::RING_DEPTH_DEF];
  int                            wr_idx;
  int                            rd_idx;
  logic [urrec_pkg::FLAG_W-1:0]  sticky_flags;
  logic [urrec_pkg::COUNT_W-1:0] drop_total;
  logic                          rx_en;

  ring_result_t expected_q [$];
  dir_row_t     dir_rows [$];
  int           gap_pct;
  int           stall_pct;
  int           fail_count;
  int           n_items, n_checked, n_pushed, n_read, n_dropped, n_diag;

  uart_receive_ring_with_error_capture_unit dut (
    .clk                  (clk),
    .rst                  (rst),
    .receiver_enable_we   (receiver_enable_we),
    .receiver_enable_wdata(receiver_enable_wdata),
    .s_tvalid             (s_tvalid),
    .s_tready             (s_tready),
    .s_tdata              (s_tdata),
    .s_tuser              (s_tuser),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
    $display("status: fail");
    $finish;
  end

  function automatic ring_result_t ring_predict(rx_item_t it);
    ring_result_t r;
    int nxt;
    r = '0;
    case (it.cmd)
      urrec_pkg::CMD_RECEIVE: begin
        if (rx_en) begin
          sticky_flags = sticky_flags | {1'b0, it.errs};
          if (it.has_byte) begin
            nxt = (wr_idx + 1) % urrec_pkg::RING_DEPTH_DEF;
            if (nxt == rd_idx) begin
              sticky_flags[urrec_pkg::FLAG_OVF] = 1'b1;
              if (drop_total != urrec_pkg::COUNT_MAX) drop_total = drop_total + 1;
              n_dropped++;
            end else begin
              ring_mem[wr_idx] = it.data;
              wr_idx = nxt;
              r.push = 1'b1;
              r.notify = 1'b1;
              n_pushed++;
            end
          end
        end
      end
      urrec_pkg::CMD_READ: begin
        if (rx_en && rd_idx != wr_idx) begin
          r.rvalid = 1'b1;
          r.rdata = ring_mem[rd_idx];
          rd_idx = (rd_idx + 1) % urrec_pkg::RING_DEPTH_DEF;
          n_read++;
        end
      end
      urrec_pkg::CMD_DIAG: begin
        r.flags = sticky_flags;
        r.dropped = drop_total;
        sticky_flags = '0;
        drop_total = '0;
        n_diag++;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic rx_item_t rand_item(mix_t mode);
    rx_item_t it;
    int pick, rx_cut, rd_cut, dg_cut, byte_pct;
    case (mode)
      MIX_FILL: begin
        rx_cut = 98; rd_cut = 99; dg_cut = 100; byte_pct = 99;
      end
      MIX_DRAIN: begin
        rx_cut = 10; rd_cut = 92; dg_cut = 97; byte_pct = 75;
      end
      default: begin
        rx_cut = 45; rd_cut = 85; dg_cut = 95; byte_pct = 75;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < rx_cut) it.cmd = urrec_pkg::CMD_RECEIVE;
    else if (pick < rd_cut) it.cmd = urrec_pkg::CMD_READ;
    else if (pick < dg_cut) it.cmd = urrec_pkg::CMD_DIAG;
    else it.cmd = CMD_SPARE;
    it.has_byte = ($urandom_range(0, 99) < byte_pct);
    it.data = 8'($urandom_range(0, 255));
    it.errs = ($urandom_range(0, 99) < 60) ? 4'd0 : 4'($urandom_range(1, 15));
    return it;
  endfunction

  function automatic ring_result_t mk_res(logic rv, logic [7:0] rd, logic push,
                                          logic [4:0] flags, logic [31:0] cnt);
    ring_result_t r;
    r = '{dropped: cnt, flags: flags, notify: push, push: push, rdata: rd, rvalid: rv};
    return r;
  endfunction

  function automatic void add_row(int cfg, logic [1:0] cmd, logic has_byte,
                                  logic [7:0] data, logic [3:0] errs, bit typed,
                                  ring_result_t res);
    dir_row_t row;
    row.cfg = cfg;
    row.item = '{errs: errs, data: data, has_byte: has_byte, cmd: cmd};
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(rx_item_t it, bit typed, ring_result_t typed_res);
    ring_result_t want;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, it.errs, it.data};
    s_tuser <= {it.has_byte, it.cmd};
    do @(posedge clk); while (!s_tready);
    want = ring_predict(it);
    expected_q.push_back(typed ? typed_res : want);
    n_items++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_receiver(logic en);
    wait_idle();
    receiver_enable_we <= 1'b1;
    receiver_enable_wdata <= en;
    @(posedge clk);
    receiver_enable_we <= 1'b0;
    rx_en = en;
  endtask

  task automatic run_random(mix_t mode, int count);
    for (int i = 0; i < count; i++) send_item(rand_item(mode), 1'b0, '0);
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    ring_result_t got;
    ring_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        check_field("read_valid", 32'(want.rvalid), 32'(got.rvalid));
        check_field("read_data", 32'(want.rdata), 32'(got.rdata));
        check_field("push_accepted", 32'(want.push), 32'(got.push));
        check_field("notify", 32'(want.notify), 32'(got.notify));
        check_field("error_flags", 32'(want.flags), 32'(got.flags));
        check_field("dropped_count", want.dropped, got.dropped);
        n_checked++;
      end
    end
  end

  initial begin
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int start_drops;
    int k;
    rst <= 1'b1;
    receiver_enable_we <= 1'b0;
    receiver_enable_wdata <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    wr_idx = 0;
    rd_idx = 0;
    sticky_flags = '0;
    drop_total = '0;
    rx_en = 1'b0;
    fail_count = 0;
    gap_pct = 20;
    stall_pct = 20;
    foreach (ring_mem[i]) ring_mem[i] = '0;

    // disabled after reset
    add_row(0, urrec_pkg::CMD_RECEIVE, 1, 8'hff, 4'hf, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_READ, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_DIAG, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, CMD_SPARE, 1, 8'ha5, 4'hf, 1, mk_res(0, 0, 0, 0, 0));
    // enabled
    add_row(1, urrec_pkg::CMD_RECEIVE, 0, 8'h77, 4'h1, 0, '0);
    add_row(-1, urrec_pkg::CMD_RECEIVE, 1, 8'h00, 4'h0, 1, mk_res(0, 8'h00, 1, 0, 0));
    add_row(-1, urrec_pkg::CMD_RECEIVE, 1, 8'hff, 4'h8, 1, mk_res(0, 8'h00, 1, 0, 0));
    add_row(-1, urrec_pkg::CMD_READ, 0, 8'h00, 4'h0, 1, mk_res(1, 8'h00, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_READ, 0, 8'hff, 4'hf, 1, mk_res(1, 8'hff, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_READ, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_DIAG, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 5'h09, 0));
    add_row(-1, urrec_pkg::CMD_DIAG, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, CMD_SPARE, 1, 8'ha5, 4'hf, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_RECEIVE, 1, 8'h5a, 4'h2, 0, '0);
    add_row(-1, urrec_pkg::CMD_RECEIVE, 1, 8'h81, 4'h4, 0, '0);
    // disabled with data held
    add_row(0, urrec_pkg::CMD_READ, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_RECEIVE, 1, 8'h33, 4'hf, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_DIAG, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 5'h06, 0));
    add_row(1, urrec_pkg::CMD_READ, 0, 8'h00, 4'h0, 1, mk_res(1, 8'h5a, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_READ, 0, 8'h00, 4'h0, 1, mk_res(1, 8'h81, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_READ, 0, 8'h00, 4'h0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(-1, urrec_pkg::CMD_DIAG, 0, 8'h00, 4'h0, 0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) set_receiver(dir_rows[i].cfg[0]);
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    end

    gap_pct = 30;
    stall_pct = 30;
    run_random(MIX_GENERAL, 100);

    set_receiver(1'b0);
    gap_pct = 20;
    stall_pct = 20;
    run_random(MIX_GENERAL, 30);

    // fill the ring, write pointer wraps, keep pushing against a full ring
    set_receiver(1'b1);
    gap_pct = 10;
    stall_pct = 40;
    start_drops = n_dropped;
    k = 0;
    while (n_dropped - start_drops < 16 && k < 2600) begin
      send_item(rand_item(MIX_FILL), 1'b0, '0);
      k++;
    end

    gap_pct = 0;
    stall_pct = 0;
    run_random(MIX_DRAIN, 50);

    wait_idle();
    $display("covered %0d transfers in, %0d results checked", n_items, n_checked);
    $display("bytes stored %0d, read %0d, dropped on full ring %0d, diagnostic takes %0d",
             n_pushed, n_read, n_dropped, n_diag);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
